FILE: design/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants, types and codes of the set-associative LRU tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

   localparam int SET_BITS     = 8;
   localparam int WAY_BITS     = 2;
   localparam int NUM_SETS     = 1 << SET_BITS;
   localparam int NUM_WAYS     = 1 << WAY_BITS;
   localparam int WAY_IDX_BITS = (WAY_BITS > 0) ? WAY_BITS : 1;

   localparam int ADDR_BITS    = 48;
   localparam int WORD_BITS    = 64;
   localparam int STAMP_BITS   = 64;
   localparam int MODE_BITS    = 2;
   localparam int OUTCOME_BITS = 3;
   localparam int WAY_OUT_BITS = 2;
   localparam int SET_OUT_BITS = 8;

   // cache kinds
   localparam logic KIND_INSN = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   // request modes; bit 1 set means clear
   localparam logic [MODE_BITS-1:0] MODE_WRITE = 2'd1;
   localparam int MODE_CLEAR_BIT = 1;

   // CSR map: register index sits at paddr[2]
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BIT   = 2;
   localparam logic CSR_IDX_CACHE_KIND = 1'b0;

   typedef enum logic [OUTCOME_BITS-1:0] {
      OUT_READ_HIT     = 3'd0,
      OUT_HIT_REPLACED = 3'd1,
      OUT_FILLED       = 3'd2,
      OUT_EVICTED      = 3'd3,
      OUT_READ_MISS    = 3'd4,
      OUT_CLEARED      = 3'd5
   } outcome_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic                  valid;
      logic [ADDR_BITS-1:0]  tag;
      logic [WORD_BITS-1:0]  word;
      logic [STAMP_BITS-1:0] stamp;
   } way_entry_type;

   typedef way_entry_type [NUM_WAYS-1:0] row_type;

   // way selection results for one set
   typedef struct packed {
      logic                    ins_found;
      logic                    ins_hit;
      logic [WAY_IDX_BITS-1:0] ins_way;
      logic                    rd_hit;
      logic [WAY_IDX_BITS-1:0] rd_way;
      logic [WAY_IDX_BITS-1:0] victim;
   } pick_type;

endpackage

`default_nettype wire

FILE: design/sacl_if.sv
// ----------------------------------------------------------------------------
// sacl_req_if / sacl_rsp_if
// Valid/ready channels for tag store requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface sacl_req_if
   import sacl_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [MODE_BITS-1:0] mode;
   logic [ADDR_BITS-1:0] address;
   logic [WORD_BITS-1:0] write_data;

   modport source (output valid, mode, address, write_data, input ready);
   modport sink   (input valid, mode, address, write_data, output ready);
endinterface

interface sacl_rsp_if
   import sacl_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [OUTCOME_BITS-1:0] outcome;
   logic [WAY_OUT_BITS-1:0] way_used;
   logic [SET_OUT_BITS-1:0] set_used;

   modport source (output valid, outcome, way_used, set_used, input ready);
   modport sink   (input valid, outcome, way_used, set_used, output ready);
endinterface

`default_nettype wire

FILE: design/sacl_way_pick.sv
// ----------------------------------------------------------------------------
// sacl_way_pick
// Per-set way selection: insert target, read hit way and LRU victim.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_way_pick
   import sacl_pkg::*;
(
   input  row_type              row,
   input  logic [ADDR_BITS-1:0] tag,
   output pick_type             pick
);

   logic [NUM_WAYS-1:0]   match;
   logic [STAMP_BITS-1:0] oldest;

   always_comb begin
      pick   = '0;
      oldest = row[0].stamp;
      for (int w = 0; w < NUM_WAYS; w++) begin
         match[w] = row[w].valid && (row[w].tag == tag);
      end
      // descending scan so the lowest qualifying way wins
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (match[w] || !row[w].valid) begin
            pick.ins_found = 1'b1;
            pick.ins_hit   = match[w];
            pick.ins_way   = WAY_IDX_BITS'(w);
         end
         if (match[w]) begin
            pick.rd_hit = 1'b1;
            pick.rd_way = WAY_IDX_BITS'(w);
         end
      end
      // strict less-than keeps ties on the lower way
      for (int w = 1; w < NUM_WAYS; w++) begin
         if (row[w].stamp < oldest) begin
            oldest      = row[w].stamp;
            pick.victim = WAY_IDX_BITS'(w);
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/set_assoc_cache_lru_tags_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags_top
// Tag store of a set-associative cache with timestamp LRU replacement.
// Timing: an accepted request captures its set row in a register; the EXEC
// state then updates the row and registers the response.
// A new request is taken only in IDLE, after EXEC has done the
// read-then-write-back of the set row through the single-port set memory.
// Reset: control, access clock and per-set live bits clear at once; cache
// kind returns to data cache. Clear touches only the live bits, no memory pass.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_tags_top
   import sacl_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   sacl_req_if.sink                      req_ch,
   sacl_rsp_if.source                    rsp_ch,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   // ---------------------------------------------------------------------
   // CSR: cache kind
   // ---------------------------------------------------------------------
   logic kind_ff;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_IDX_BIT] == CSR_IDX_CACHE_KIND) begin
         csr_prdata = CSR_DATA_BITS'(kind_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;
   logic      req_accept;
   logic      exec;
   logic      rsp_valid_ff;

   // A request enters only when the response register is free at the edge,
   // so the response slot is always empty by the time EXEC finishes.
   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign exec         = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Request capture
   // ---------------------------------------------------------------------
   logic [MODE_BITS-1:0]  mode_ff;
   logic [ADDR_BITS-1:0]  addr_ff;
   logic [WORD_BITS-1:0]  word_ff;
   logic [SET_BITS-1:0]   set_ff;
   logic [SET_BITS-1:0]   req_set;
   logic [STAMP_BITS-1:0] clock_ff;

   // set index: address bits just above the way bits
   assign req_set = req_ch.address[WAY_BITS +: SET_BITS];

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff <= req_ch.mode;
         addr_ff <= req_ch.address;
         word_ff <= req_ch.write_data;
         set_ff  <= req_set;
      end
   end

   // ---------------------------------------------------------------------
   // Set memory: one row holds all ways of a set; row live bits stand in
   // for the reset/clear value (row not live reads as all ways invalid)
   // ---------------------------------------------------------------------
   row_type             set_mem [NUM_SETS];
   row_type             rd_row_ff;
   logic                rd_live_ff;
   logic [NUM_SETS-1:0] row_live_ff;
   row_type             eff_row;
   row_type             new_row;
   logic                mem_we;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_row_ff  <= set_mem[req_set];
         rd_live_ff <= row_live_ff[req_set];
      end
      if (exec && mem_we) begin
         set_mem[set_ff] <= new_row;
      end
   end

   assign eff_row = rd_live_ff ? rd_row_ff : '0;

   // ---------------------------------------------------------------------
   // Way selection and row update
   // ---------------------------------------------------------------------
   pick_type                pick;
   logic                    is_clear;
   logic                    is_insert;
   outcome_type             outcome;
   logic [WAY_IDX_BITS-1:0] way_sel;

   sacl_way_pick u_way_pick (
      .row  (eff_row),
      .tag  (addr_ff),
      .pick (pick)
   );

   always_comb begin
      is_clear  = mode_ff[MODE_CLEAR_BIT];
      is_insert = !is_clear && ((kind_ff == KIND_INSN) || (mode_ff == MODE_WRITE));
      new_row   = eff_row;
      mem_we    = 1'b0;
      outcome   = OUT_READ_MISS;
      way_sel   = '0;
      if (is_clear) begin
         outcome = OUT_CLEARED;
      end else if (is_insert) begin
         mem_we = 1'b1;
         if (pick.ins_found) begin
            way_sel = pick.ins_way;
            outcome = pick.ins_hit ? OUT_HIT_REPLACED : OUT_FILLED;
         end else begin
            way_sel = pick.victim;
            outcome = OUT_EVICTED;
         end
         new_row[way_sel] = '{valid: 1'b1, tag: addr_ff, word: word_ff, stamp: clock_ff};
      end else if (pick.rd_hit) begin
         // read hit: refresh stamp only
         mem_we                 = 1'b1;
         way_sel                = pick.rd_way;
         new_row[way_sel].stamp = clock_ff;
         outcome                = OUT_READ_HIT;
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   outcome_type             rsp_outcome_ff;
   logic [WAY_OUT_BITS-1:0] rsp_way_ff;
   logic [SET_OUT_BITS-1:0] rsp_set_ff;

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_outcome_ff <= outcome;
         rsp_way_ff     <= WAY_OUT_BITS'(way_sel);
         rsp_set_ff     <= SET_OUT_BITS'(set_ff);
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.outcome  = rsp_outcome_ff;
   assign rsp_ch.way_used = rsp_way_ff;
   assign rsp_ch.set_used = rsp_set_ff;

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clock_ff     <= '0;
         kind_ff      <= KIND_DATA;
         row_live_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr && (csr_paddr[CSR_IDX_BIT] == CSR_IDX_CACHE_KIND)) begin
            kind_ff <= csr_pwdata[0];
         end
         // access clock ticks on every read or write, not on clear
         if (req_accept && !req_ch.mode[MODE_CLEAR_BIT]) begin
            clock_ff <= clock_ff + STAMP_BITS'(1);
         end
         if (exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (exec && is_clear) begin
            row_live_ff <= '0;
         end else if (exec && mem_we) begin
            row_live_ff[set_ff] <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response raised without an executed request");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      exec |-> !rsp_valid_ff)
      else $error("response register busy while a request executes");

   a_clock_tick: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_ch.mode[MODE_CLEAR_BIT]) |=>
         (clock_ff == $past(clock_ff) + STAMP_BITS'(1)))
      else $error("access clock did not advance on an access");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (exec && is_clear) |=> (row_live_ff == '0))
      else $error("clear left a live set");

   a_no_write_on_clear: assert property (@(posedge clock) disable iff (reset)
      (exec && is_clear) |-> !mem_we)
      else $error("set memory written during clear");

endmodule

`default_nettype wire
